// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the taskfile builder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/atb_pkg.sv =====
// Types, codes and constants of the ATA taskfile builder.
package atb_pkg;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_GEO = 2'd2;

   // Layout codes
   localparam logic [2:0] LAYOUT_CHS     = 3'd0;
   localparam logic [2:0] LAYOUT_LBA28   = 3'd1;
   localparam logic [2:0] LAYOUT_LBA28_Q = 3'd2;
   localparam logic [2:0] LAYOUT_LBA48   = 3'd3;
   localparam logic [2:0] LAYOUT_LBA48_Q = 3'd4;

   // Register indexes
   localparam logic [1:0] REG_LBA_EN   = 2'd0;
   localparam logic [1:0] REG_LBA48_EN = 2'd1;
   localparam logic [1:0] REG_HEADS    = 2'd2;
   localparam logic [1:0] REG_SPT      = 2'd3;

   // Command opcodes
   localparam logic [7:0] OP_READ_PIO     = 8'h20;
   localparam logic [7:0] OP_WRITE_PIO    = 8'h30;
   localparam logic [7:0] OP_READ_DMA     = 8'hC8;
   localparam logic [7:0] OP_WRITE_DMA    = 8'hCA;
   localparam logic [7:0] OP_READ_PIO48   = 8'h24;
   localparam logic [7:0] OP_WRITE_PIO48  = 8'h34;
   localparam logic [7:0] OP_READ_DMA48   = 8'h25;
   localparam logic [7:0] OP_WRITE_DMA48  = 8'h35;
   localparam logic [7:0] OP_READ_Q       = 8'hC7;
   localparam logic [7:0] OP_WRITE_Q      = 8'hCC;
   localparam logic [7:0] OP_READ_Q48     = 8'h26;
   localparam logic [7:0] OP_WRITE_Q48    = 8'h36;

   // Limits
   localparam logic [48:0] LBA28_LIMIT     = 49'h000000fffffff;
   localparam logic [16:0] LBA28_MAX_COUNT = 17'h00100;
   localparam logic [16:0] LBA48_MAX_COUNT = 17'h0ffff;

   localparam int TRACK_W = 13;

   // Command fields decided up front, carried alongside the dividers
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  layout;
      logic [7:0]  opcode;
      logic [15:0] count;
      logic [4:0]  tag;
      logic [47:0] lba;
      logic        chs_fill;
   } atb_cmd_type;

   function automatic logic [7:0] pick_opcode(logic wr, logic dma, logic wide);
      logic [7:0] op;
      if (wide) begin
         if (dma) op = wr ? OP_WRITE_DMA48 : OP_READ_DMA48;
         else     op = wr ? OP_WRITE_PIO48 : OP_READ_PIO48;
      end else begin
         if (dma) op = wr ? OP_WRITE_DMA : OP_READ_DMA;
         else     op = wr ? OP_WRITE_PIO : OP_READ_PIO;
      end
      return op;
   endfunction

endpackage

// ===== hw/rtl/atb_decode.sv =====
// Front stage: picks the layout, opcode, status, count, tag and LBA for each request.
module atb_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [47:0]         start_block,
   input  logic [16:0]         block_total,
   input  logic                write_req,
   input  logic                use_dma,
   input  logic                queued,
   input  logic [4:0]          queue_tag,
   input  logic                lba_enable,
   input  logic                lba48_enable,
   input  logic [atb_pkg::TRACK_W-1:0] track,
   output logic                out_valid,
   output logic [47:0]         out_start,
   output atb_pkg::atb_cmd_type out_cmd
);

   logic                 valid_ff;
   logic [47:0]          start_ff;
   atb_pkg::atb_cmd_type cmd_ff;
   atb_pkg::atb_cmd_type cmd_in;
   logic                 over28;
   logic                 wide;
   logic [48:0]          end_blk;

   assign end_blk = {1'b0, start_block} + {32'd0, block_total};
   assign over28  = block_total > atb_pkg::LBA28_MAX_COUNT;
   assign wide    = lba48_enable && ((end_blk > atb_pkg::LBA28_LIMIT) || over28);

   // Decide the command fields
   always_comb begin
      cmd_in = '0;
      if (lba_enable) begin
         if (wide) begin
            if (block_total > atb_pkg::LBA48_MAX_COUNT) begin
               cmd_in.status = atb_pkg::STATUS_INVALID;
            end else begin
               cmd_in.count = block_total[15:0];
               cmd_in.lba   = start_block;
               if (queued) begin
                  cmd_in.layout = atb_pkg::LAYOUT_LBA48_Q;
                  cmd_in.opcode = write_req ? atb_pkg::OP_WRITE_Q48 : atb_pkg::OP_READ_Q48;
                  cmd_in.tag    = queue_tag;
               end else begin
                  cmd_in.layout = atb_pkg::LAYOUT_LBA48;
                  cmd_in.opcode = atb_pkg::pick_opcode(write_req, use_dma, 1'b1);
               end
            end
         end else if (over28) begin
            cmd_in.status = atb_pkg::STATUS_INVALID;
         end else begin
            cmd_in.count = {8'd0, block_total[7:0]};
            cmd_in.lba   = {20'd0, start_block[27:0]};
            if (queued) begin
               cmd_in.layout = atb_pkg::LAYOUT_LBA28_Q;
               cmd_in.opcode = write_req ? atb_pkg::OP_WRITE_Q : atb_pkg::OP_READ_Q;
               cmd_in.tag    = queue_tag;
            end else begin
               cmd_in.layout = atb_pkg::LAYOUT_LBA28;
               cmd_in.opcode = atb_pkg::pick_opcode(write_req, use_dma, 1'b0);
            end
         end
      end else if (over28) begin
         cmd_in.status = atb_pkg::STATUS_INVALID;
      end else if (track == '0) begin
         cmd_in.status = atb_pkg::STATUS_ZERO_GEO;
      end else begin
         cmd_in.layout   = atb_pkg::LAYOUT_CHS;
         cmd_in.opcode   = atb_pkg::pick_opcode(write_req, use_dma, 1'b0);
         cmd_in.count    = {8'd0, block_total[7:0]};
         cmd_in.chs_fill = 1'b1;
      end
   end

   // Hold the decision
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff <= start_block;
         cmd_ff   <= cmd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_start = start_ff;
   assign out_cmd   = cmd_ff;

endmodule

// ===== hw/rtl/atb_divpipe.sv =====
// Restoring divider, one quotient bit per pipeline stage, with side payload.
module atb_divpipe #(
   parameter int N = 48,
   parameter int D = 13,
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [N-1:0] in_dividend,
   input  logic [D-1:0] divisor,
   input  logic [W-1:0] in_payload,
   output logic         out_valid,
   output logic [N-1:0] out_quotient,
   output logic [D-1:0] out_remainder,
   output logic [W-1:0] out_payload
);

   logic [D-1:0] rem_ff  [N];
   logic [N-1:0] word_ff [N];
   logic [W-1:0] pay_ff  [N];
   logic         vld_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [D-1:0] rem_src;
      logic [N-1:0] word_src;
      logic [W-1:0] pay_src;
      logic         vld_src;
      logic [D:0]   trial;
      logic [D:0]   diff;
      logic         take;
      logic [D-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign word_src = in_dividend;
         assign pay_src  = in_payload;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign word_src = word_ff[k-1];
         assign pay_src  = pay_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      // Shift in the next dividend bit and try the subtract
      assign trial  = {rem_src, word_src[N-1]};
      assign diff   = trial - {1'b0, divisor};
      assign take   = trial >= {1'b0, divisor};
      assign rem_in = take ? diff[D-1:0] : trial[D-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            word_ff[k] <= {word_src[N-2:0], take};
            pay_ff[k]  <= pay_src;
         end
      end
   end

   assign out_valid     = vld_ff[N-1];
   assign out_quotient  = word_ff[N-1];
   assign out_remainder = rem_ff[N-1];
   assign out_payload   = pay_ff[N-1];

endmodule

// ===== hw/rtl/ata_rw_taskfile_builder.sv =====
// Top level of the ATA read/write taskfile builder.
// Takes one read/write request per cycle unless the result stalls, and returns one
// taskfile per request, in order. It has one decode stage, 48 stages of the cylinder
// divider (start block over heads times sectors, one quotient bit per stage), 13 stages
// of the head/sector divider and the output register. A stalled result holds the whole
// pipeline; the request side is ready when the result register is empty or being taken.
// Registers: 0 LBA enable, 1 LBA48 enable, 2 head count, 3 sectors per track; write
// them only while no request is in flight.
`include "assert_macros.svh"

module ata_rw_taskfile_builder (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // start_block[47:0], block_total[64:48], write_req[65], use_dma[66], queued[67],
   // queue_tag[72:68], zero fill to 80 bits
   input  logic [79:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], layout[4:2], opcode[12:5], count_field[28:13], tag_field[33:29],
   // lba_field[81:34], cylinder_field[97:82], head_field[101:98],
   // sector_field[109:102], zero fill to 112 bits
   output logic [111:0]  rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata
);

   localparam int TW    = atb_pkg::TRACK_W;
   localparam int CMD_W = $bits(atb_pkg::atb_cmd_type);

   logic       lba_en_ff;
   logic       lba48_en_ff;
   logic [4:0] heads_ff;
   logic [7:0] spt_ff;
   logic [TW-1:0] track;
   logic       advance;

   logic                 dec_valid;
   logic [47:0]          dec_start;
   atb_pkg::atb_cmd_type dec_cmd;

   logic                 d1_valid;
   logic [47:0]          d1_quot;
   logic [TW-1:0]        d1_rem;
   logic [CMD_W-1:0]     d1_pay;

   logic                 d2_valid;
   logic [TW-1:0]        d2_quot;
   logic [7:0]           d2_rem;
   logic [CMD_W+15:0]    d2_pay;
   atb_pkg::atb_cmd_type fin_cmd;
   logic [15:0]          fin_cyl;

   logic                 out_valid_ff;
   logic [111:0]         out_data_ff;
   logic [111:0]         out_data_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lba_en_ff   <= 1'b1;
         lba48_en_ff <= 1'b0;
         heads_ff    <= 5'd16;
         spt_ff      <= 8'd63;
      end else if (csr_wr_en) begin
         case (csr_index)
            atb_pkg::REG_LBA_EN:   lba_en_ff   <= csr_wdata[0];
            atb_pkg::REG_LBA48_EN: lba48_en_ff <= csr_wdata[0];
            atb_pkg::REG_HEADS:    heads_ff    <= csr_wdata[4:0];
            atb_pkg::REG_SPT:      spt_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The user must keep track size static while requests are in flight; the block does not enforce it
   assign track   = {8'd0, heads_ff} * {5'd0, spt_ff};
   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   atb_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .start_block  (req_tdata[47:0]),
      .block_total  (req_tdata[64:48]),
      .write_req    (req_tdata[65]),
      .use_dma      (req_tdata[66]),
      .queued       (req_tdata[67]),
      .queue_tag    (req_tdata[72:68]),
      .lba_enable   (lba_en_ff),
      .lba48_enable (lba48_en_ff),
      .track        (track),
      .out_valid    (dec_valid),
      .out_start    (dec_start),
      .out_cmd      (dec_cmd)
   );

   // Cylinder and offset within the cylinder
   atb_divpipe #(.N(48), .D(TW), .W(CMD_W)) u_div_cyl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (dec_valid),
      .in_dividend   (dec_start),
      .divisor       (track),
      .in_payload    (dec_cmd),
      .out_valid     (d1_valid),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem),
      .out_payload   (d1_pay)
   );

   // Head and zero-based sector
   atb_divpipe #(.N(TW), .D(8), .W(CMD_W + 16)) u_div_sec (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (d1_valid),
      .in_dividend   (d1_rem),
      .divisor       (spt_ff),
      .in_payload    ({d1_pay, d1_quot[15:0]}),
      .out_valid     (d2_valid),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem),
      .out_payload   (d2_pay)
   );

   assign fin_cmd = d2_pay[CMD_W+15:16];
   assign fin_cyl = d2_pay[15:0];

   // Pack the result
   always_comb begin
      out_data_in           = '0;
      out_data_in[1:0]      = fin_cmd.status;
      out_data_in[4:2]      = fin_cmd.layout;
      out_data_in[12:5]     = fin_cmd.opcode;
      out_data_in[28:13]    = fin_cmd.count;
      out_data_in[33:29]    = fin_cmd.tag;
      out_data_in[81:34]    = fin_cmd.lba;
      if (fin_cmd.chs_fill) begin
         out_data_in[97:82]   = fin_cyl;
         out_data_in[101:98]  = d2_quot[3:0];
         out_data_in[109:102] = d2_rem + 8'd1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `ASSERT_IMPLY(a_err_no_op, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != atb_pkg::STATUS_OK), rsp_tdata[12:5] == 8'd0)
   `ASSERT_IMPLY(a_chs_no_lba, clock, reset, rsp_tvalid && (rsp_tdata[4:2] == atb_pkg::LAYOUT_CHS), rsp_tdata[81:34] == 48'd0)
   `ASSERT_IMPLY(a_lba_no_chs, clock, reset, rsp_tvalid && (rsp_tdata[4:2] != atb_pkg::LAYOUT_CHS), rsp_tdata[109:82] == 28'd0)
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule
